/* design/mms_pkg.sv */
// mms_pkg: shared types and constants for the min/max stack
// item structs, status and operation codes, storage sizes
// no dependencies

package mms_pkg;

  localparam int DEPTH   = 64;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW      = $clog2(DEPTH + 1);
  localparam int DEPTH_W = 7;
  localparam int WORD_W  = 32;
  localparam int STAT_W  = 2;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic                     op;
    logic signed [WORD_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] popped_value;
    logic signed [WORD_W-1:0] top_value;
    logic signed [WORD_W-1:0] min_value;
    logic signed [WORD_W-1:0] max_value;
    logic [DEPTH_W-1:0]       depth;
    logic [STAT_W-1:0]        status;
  } out_t;

  // one stack entry: value plus min and max from the bottom up to it
  typedef struct packed {
    logic signed [WORD_W-1:0] val;
    logic signed [WORD_W-1:0] min;
    logic signed [WORD_W-1:0] max;
  } entry_t;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    entry_t        wdata;
  } mem_req_t;

endpackage

/* design/mms_mem.sv */
// mms_mem: entry memory for the stack, one write and one registered read per cycle
// holds every entry below the two cached top entries
// depends on mms_pkg

module mms_mem (
  input  logic                clk_i,
  input  mms_pkg::mem_req_t   req_i,
  output mms_pkg::entry_t     rdata_o
);

  mms_pkg::entry_t mem [mms_pkg::DEPTH];
  mms_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    // forward a write to the same address so the read side never goes stale
    if (req_i.we && (req_i.waddr == req_i.raddr)) begin
      rdata_q <= req_i.wdata;
    end else begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/mms_stack.sv */
// mms_stack: fill count, cached top and second entries, push/pop update
// drives the entry memory and forms one result per item
// depends on mms_pkg

module mms_stack (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  mms_pkg::in_t      item_i,
  input  mms_pkg::entry_t   rdata_i,
  output mms_pkg::mem_req_t req_o,
  output mms_pkg::out_t     res_o
);

  logic [mms_pkg::CW-1:0] count_q, count_d;
  mms_pkg::entry_t        top_q, top_d;
  mms_pkg::entry_t        sec_q, sec_d;
  mms_pkg::entry_t        new_entry;
  logic [mms_pkg::STAT_W-1:0] status;
  logic signed [mms_pkg::WORD_W-1:0] popped;
  logic                   full;
  logic                   we;

  assign full = (count_q == mms_pkg::CW'(mms_pkg::DEPTH));

  always_comb begin
    new_entry.val = item_i.value;
    if (count_q == '0) begin
      new_entry.min = item_i.value;
      new_entry.max = item_i.value;
    end else begin
      new_entry.min = (item_i.value < top_q.min) ? item_i.value : top_q.min;
      new_entry.max = (top_q.max < item_i.value) ? item_i.value : top_q.max;
    end
  end

  always_comb begin
    count_d = count_q;
    top_d   = top_q;
    sec_d   = sec_q;
    status  = mms_pkg::ST_OK;
    popped  = '0;
    we      = 1'b0;
    if (accept_i) begin
      if (item_i.op == mms_pkg::OP_PUSH) begin
        if (full) begin
          status = mms_pkg::ST_FULL;
        end else begin
          top_d   = new_entry;
          sec_d   = top_q;
          // the old second entry spills into memory
          we      = (count_q >= mms_pkg::CW'(2));
          count_d = count_q + mms_pkg::CW'(1);
        end
      end else begin
        if (count_q == '0) begin
          status = mms_pkg::ST_EMPTY;
        end else begin
          popped  = top_q.val;
          top_d   = sec_q;
          sec_d   = rdata_i;
          count_d = count_q - mms_pkg::CW'(1);
        end
      end
    end
  end

  always_comb begin
    req_o.we    = we;
    req_o.waddr = mms_pkg::AW'(count_q - mms_pkg::CW'(2));
    // keep the entry under the new second one loaded for the next pop
    req_o.raddr = mms_pkg::AW'(count_d - mms_pkg::CW'(3));
    req_o.wdata = sec_q;
  end

  always_comb begin
    res_o.popped_value = popped;
    res_o.depth        = mms_pkg::DEPTH_W'(count_d);
    res_o.status       = status;
    if (count_d == '0) begin
      res_o.top_value = '0;
      res_o.min_value = '0;
      res_o.max_value = '0;
    end else begin
      res_o.top_value = top_d.val;
      res_o.min_value = top_d.min;
      res_o.max_value = top_d.max;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    sec_q <= sec_d;
  end

endmodule

/* design/mms_out_reg.sv */
// mms_out_reg: result register with valid/stall handshake
// loads a new result whenever load_i is high
// depends on mms_pkg

module mms_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  mms_pkg::out_t res_i,
  input  logic          out_stall_i,
  output logic          busy_o,
  output logic          out_valid_o,
  output mms_pkg::out_t out_item_o
);

  logic          valid_q, valid_d;
  mms_pkg::out_t item_q;

  assign busy_o = valid_q && out_stall_i;

  always_comb begin
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_stall_i) begin
      valid_d = valid_q;
    end else begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

/* design/min_max_stack.sv */
// min_max_stack: signed word stack tracking running minimum and maximum
// top level, ties stack control, entry memory and result register together
// depends on mms_pkg, mms_mem, mms_stack, mms_out_reg
//
//   channel  | valid        | stall        | payload
//   ---------+--------------+--------------+-------------------------
//   input    | in_valid_i   | in_stall_o   | in_item_i  (mms_pkg::in_t)
//   result   | out_valid_o  | out_stall_i  | out_item_o (mms_pkg::out_t)
//
// one item per cycle unless stalled; its result is registered in the next cycle
// the top two entries sit in registers, so a pop needs no memory read in its
// own cycle: the memory read port keeps the third entry registered and ready
// reset clears the fill count and the result valid; memory contents need no clearing
// input stalls only while a held result is itself stalled

module min_max_stack (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  mms_pkg::in_t  in_item_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output mms_pkg::out_t out_item_o
);

  logic              accept;
  logic              busy;
  mms_pkg::mem_req_t mem_req;
  mms_pkg::entry_t   mem_rdata;
  mms_pkg::out_t     res;

  assign in_stall_o = busy;
  assign accept     = in_valid_i && !busy;

  mms_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  mms_stack u_stack (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_item_i),
    .rdata_i  (mem_rdata),
    .req_o    (mem_req),
    .res_o    (res)
  );

  mms_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .res_i       (res),
    .out_stall_i (out_stall_i),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule

/* design/mms_checker.sv */
// mms_checker: port level assertions for min_max_stack
// bound to the top level at the end of this file
// depends on mms_pkg

module mms_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input mms_pkg::out_t out_item_o
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // an accepted item always yields a result next cycle
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted item gave no result");

  // empty stack reports zero top, min and max
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.depth == '0) |->
      (out_item_o.top_value == '0) && (out_item_o.min_value == '0) &&
      (out_item_o.max_value == '0))
    else $error("empty stack reports nonzero data");

  // refusals only at the bounds
  a_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ((out_item_o.status != mms_pkg::ST_FULL) ||
       (out_item_o.depth == mms_pkg::DEPTH_W'(mms_pkg::DEPTH))) &&
      ((out_item_o.status != mms_pkg::ST_EMPTY) || (out_item_o.depth == '0)))
    else $error("refusal away from stack bound");

  // top lies between min and max
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.depth != '0) |->
      (out_item_o.min_value <= out_item_o.top_value) &&
      (out_item_o.top_value <= out_item_o.max_value))
    else $error("top outside min/max range");

endmodule

bind min_max_stack mms_checker u_mms_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
